// File: sv/hswt_pkg.sv
// hswt_pkg: shared types and constants for the handle set with tags
// request and result field layouts, operation codes and controller states
// no dependencies
package hswt_pkg;

    localparam int KIND_W  = 3;
    localparam int FIELD_W = 32;
    localparam int POS_W   = 6;
    localparam int ENT_W   = 7;

    typedef enum logic [KIND_W-1:0] {
        OP_ADD     = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_GET_POS = 3'd2,
        OP_FIND    = 3'd3,
        OP_SET_TAG = 3'd4,
        OP_GET_TAG = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_SCAN,
        ST_SHIFT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] key;
        logic [POS_W-1:0]   pos;
        logic [FIELD_W-1:0] tag;
    } req_t;

    typedef struct packed {
        logic               full_res;
        logic [ENT_W-1:0]   entries;
        logic [FIELD_W-1:0] tag_out;
        logic [FIELD_W-1:0] key_out;
        logic [POS_W-1:0]   slot;
        logic               found;
    } res_t;

endpackage

// File: sv/handle_set_with_tags.sv
// handle_set_with_tags: ordered duplicate-free key set with per-key tag words
// null, unused or out-of-range requests produce a result directly; get by position reads
// one key; lookups compare entries in order (one key memory read per cycle); a remove
// then moves the later entries down one slot; one request in flight, the next
// accepted the cycle after a result enters the output register
// synchronous active-low reset empties the set; memories need no clearing
module handle_set_with_tags #(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32,
    parameter int TAG_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // key[31:0], position[37:32], tag_in[69:38], zero pad
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // found[0], slot[6:1], key_out[38:7], tag_out[70:39],
                                   // entries[77:71], full_res[78], zero pad
);

    hswt_pkg::req_t req;
    hswt_pkg::res_t res, out_reg, out_next;
    logic           res_valid, res_ready;
    logic           out_valid_reg, out_valid_next;

    assign req.kind = s_tuser;
    assign req.key  = s_tdata[31:0];
    assign req.pos  = s_tdata[37:32];
    assign req.tag  = s_tdata[69:38];

    hswt_ctrl #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready) begin
            out_next       = res;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.full_res, out_reg.entries, out_reg.tag_out,
                       out_reg.key_out, out_reg.slot, out_reg.found};

endmodule

// File: sv/hswt_ram.sv
// hswt_ram: simple dual-port synchronous memory, one write and one read port
// read data is registered
// no dependencies
module hswt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/hswt_ctrl.sv
// hswt_ctrl: sequencer for the handle set; scans the key memory, appends,
// updates tags and compacts entries after a remove
// depends on hswt_pkg and hswt_ram
module hswt_ctrl #(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32,
    parameter int TAG_WIDTH = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_valid,
    output logic          req_ready,
    input  hswt_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output hswt_pkg::res_t res
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > hswt_pkg::POS_W) ? CW : hswt_pkg::POS_W;

    hswt_pkg::state_t state_reg, state_next;
    hswt_pkg::op_t    op_reg, op_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [TAG_WIDTH-1:0] tag_reg, tag_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        scan_idx_reg, scan_idx_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic [AW-1:0]        wr_addr_reg, wr_addr_next;
    hswt_pkg::res_t       res_reg, res_next;

    logic                 key_we, tag_we;
    logic [AW-1:0]        key_waddr, tag_waddr, raddr;
    logic [KEY_WIDTH-1:0] key_wdata, key_rdata;
    logic [TAG_WIDTH-1:0] tag_wdata, tag_rdata;

    logic [KEY_WIDTH-1:0] req_key;
    logic [TAG_WIDTH-1:0] req_tag;
    logic [CMPW-1:0]      pos_ext, cnt_ext;
    logic                 pos_ok, scan_ok, hit, scan_more, is_full;
    logic [CW-1:0]        shift_wa;

    hswt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (raddr),
        .rdata (key_rdata)
    );

    hswt_ram #(.WIDTH(TAG_WIDTH), .DEPTH(DEPTH)) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (raddr),
        .rdata (tag_rdata)
    );

    assign req_key   = KEY_WIDTH'(req.key);
    assign req_tag   = TAG_WIDTH'(req.tag);
    assign pos_ext   = CMPW'(req.pos);
    assign cnt_ext   = CMPW'(count_reg);
    assign pos_ok    = pos_ext < cnt_ext;
    assign scan_ok   = (req_key != '0) &&
                       ((req.kind == hswt_pkg::OP_ADD)     ||
                        (req.kind == hswt_pkg::OP_REMOVE)  ||
                        (req.kind == hswt_pkg::OP_FIND)    ||
                        (req.kind == hswt_pkg::OP_SET_TAG) ||
                        (req.kind == hswt_pkg::OP_GET_TAG));
    // compare stage checks the key read in the previous cycle
    assign hit       = cmp_valid_reg && (key_rdata == key_reg);
    assign scan_more = scan_idx_reg < count_reg;
    assign is_full   = count_reg == CW'(DEPTH);
    assign shift_wa  = scan_idx_reg - CW'(1);

    assign req_ready = state_reg == hswt_pkg::ST_IDLE;
    assign res_valid = state_reg == hswt_pkg::ST_FIN;

    always_comb begin
        res         = res_reg;
        res.entries = hswt_pkg::ENT_W'(count_reg);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hswt_pkg::ST_IDLE: begin
                if (req_valid) begin
                    if (req.kind == hswt_pkg::OP_GET_POS && pos_ok) begin
                        state_next = hswt_pkg::ST_POS;
                    end else if (scan_ok) begin
                        state_next = hswt_pkg::ST_SCAN;
                    end else begin
                        state_next = hswt_pkg::ST_FIN;
                    end
                end
            end
            hswt_pkg::ST_POS: state_next = hswt_pkg::ST_FIN;
            hswt_pkg::ST_SCAN: begin
                if (hit) begin
                    state_next = (op_reg == hswt_pkg::OP_REMOVE) ? hswt_pkg::ST_SHIFT
                                                                 : hswt_pkg::ST_FIN;
                end else if (!scan_more) begin
                    state_next = hswt_pkg::ST_FIN;
                end
            end
            hswt_pkg::ST_SHIFT: begin
                if (!scan_more) begin
                    state_next = hswt_pkg::ST_FIN;
                end
            end
            hswt_pkg::ST_FIN: begin
                if (res_ready) begin
                    state_next = hswt_pkg::ST_IDLE;
                end
            end
            default: state_next = hswt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        op_next        = op_reg;
        key_next       = key_reg;
        tag_next       = tag_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        wr_pend_next   = wr_pend_reg;
        wr_addr_next   = wr_addr_reg;
        res_next       = res_reg;
        key_we         = 1'b0;
        tag_we         = 1'b0;
        key_waddr      = count_reg[AW-1:0];
        tag_waddr      = count_reg[AW-1:0];
        key_wdata      = key_reg;
        tag_wdata      = '0;
        raddr          = scan_idx_reg[AW-1:0];

        unique case (state_reg)
            hswt_pkg::ST_IDLE: begin
                raddr = pos_ext[AW-1:0];
                if (req_valid) begin
                    op_next        = hswt_pkg::op_t'(req.kind);
                    key_next       = req_key;
                    tag_next       = req_tag;
                    scan_idx_next  = '0;
                    cmp_valid_next = 1'b0;
                    res_next       = '0;
                    if (req.kind == hswt_pkg::OP_GET_POS && pos_ok) begin
                        res_next.slot = req.pos;
                    end
                end
            end
            hswt_pkg::ST_POS: begin
                res_next.found   = 1'b1;
                res_next.key_out = hswt_pkg::FIELD_W'(key_rdata);
            end
            hswt_pkg::ST_SCAN: begin
                if (hit) begin
                    res_next.found = 1'b1;
                    res_next.slot  = hswt_pkg::POS_W'(cmp_idx_reg);
                    unique case (op_reg)
                        hswt_pkg::OP_GET_TAG: begin
                            res_next.tag_out = hswt_pkg::FIELD_W'(tag_rdata);
                        end
                        hswt_pkg::OP_SET_TAG: begin
                            tag_we    = 1'b1;
                            tag_waddr = cmp_idx_reg;
                            tag_wdata = tag_reg;
                        end
                        hswt_pkg::OP_REMOVE: begin
                            // compaction starts from the entry after the hit
                            scan_idx_next = CW'(cmp_idx_reg) + CW'(1);
                            wr_pend_next  = 1'b0;
                        end
                        default: ;
                    endcase
                end else if (scan_more) begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[AW-1:0];
                    scan_idx_next  = scan_idx_reg + CW'(1);
                end else begin
                    cmp_valid_next = 1'b0;
                    if (op_reg == hswt_pkg::OP_ADD || op_reg == hswt_pkg::OP_SET_TAG) begin
                        if (is_full) begin
                            res_next.full_res = 1'b1;
                        end else begin
                            key_we     = 1'b1;
                            tag_we     = 1'b1;
                            tag_wdata  = (op_reg == hswt_pkg::OP_SET_TAG) ? tag_reg : '0;
                            count_next = count_reg + CW'(1);
                            if (op_reg == hswt_pkg::OP_SET_TAG) begin
                                res_next.found = 1'b1;
                                res_next.slot  = hswt_pkg::POS_W'(count_reg);
                            end
                        end
                    end
                end
            end
            hswt_pkg::ST_SHIFT: begin
                // read entry i+1, and write it to i in the next cycle
                if (wr_pend_reg) begin
                    key_we    = 1'b1;
                    tag_we    = 1'b1;
                    key_waddr = wr_addr_reg;
                    tag_waddr = wr_addr_reg;
                    key_wdata = key_rdata;
                    tag_wdata = tag_rdata;
                end
                if (scan_more) begin
                    wr_pend_next  = 1'b1;
                    wr_addr_next  = shift_wa[AW-1:0];
                    scan_idx_next = scan_idx_reg + CW'(1);
                end else begin
                    wr_pend_next = 1'b0;
                    count_next   = count_reg - CW'(1);
                end
            end
            hswt_pkg::ST_FIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= hswt_pkg::ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            wr_pend_reg   <= wr_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        tag_reg      <= tag_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        wr_addr_reg  <= wr_addr_next;
        res_reg      <= res_next;
    end

endmodule

// File: sv/hswt_chk.sv
// hswt_chk: port-level checks on the result channel of handle_set_with_tags
// bound to the top level; depends on nothing else
module hswt_chk #(
    parameter int DEPTH = 64
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // a held result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a refused add or set-tag never reports a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[78] |-> !m_tdata[0])
        else $error("full and found together");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == 6'd0 && m_tdata[38:7] == 32'd0)
        else $error("miss with nonzero slot or key");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (DEPTH > 127) || (m_tdata[77:71] <= 7'(DEPTH)))
        else $error("entry count beyond depth");

endmodule

bind handle_set_with_tags hswt_chk #(.DEPTH(DEPTH)) u_hswt_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
